// ----- hdl/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the servo packet framer
// Beat kinds, queue entry and result layouts, packet constants.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

  localparam logic [7:0] HDR0       = 8'hFA;
  localparam logic [7:0] HDR1       = 8'hAF;
  localparam logic [7:0] READ_FLAGS = 8'h0F;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  // byte position inside a packet or reply (up to 7 + 7)
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_DATA0 = 4'd7;  // first data byte
  localparam logic [POS_W-1:0] POS_XOR0  = 4'd2;  // first checksummed byte

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_RX    = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_read;
    logic [7:0]  servo_id;
    logic [7:0]  flag_byte;
    logic [7:0]  reg_address;
    logic [2:0]  data_length;   // already limited
    logic [7:0]  servo_count;
    logic [31:0] data_word;
    logic [7:0]  rx_byte;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        reply_valid;
    logic        reply_ok;
    logic [31:0] reply_data;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/spf_front.sv -----
// ----------------------------------------------------------------------------
// spf_front: input decode and command queue
// Unpacks input beats, limits the length, flags read requests, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_front #(
  parameter int unsigned MAX_DATA_BYTES = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [spf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               in_tuser,
  output spf_pkg::head_t                          head,
  input  wire logic                               pop
);

  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

  spf_pkg::entry_t q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  spf_pkg::entry_t dec;
  logic            push;
  logic            do_pop;

  always_comb begin
    dec.kind        = spf_pkg::kind_t'(in_tuser);
    dec.servo_id    = in_tdata[7:0];
    dec.flag_byte   = in_tdata[15:8];
    dec.reg_address = in_tdata[23:16];
    dec.servo_count = in_tdata[34:27];
    dec.data_word   = in_tdata[66:35];
    dec.rx_byte     = in_tdata[74:67];
    if ({1'b0, in_tdata[26:24]} > MAX_LEN) begin
      dec.data_length = MAX_LEN[2:0];
    end else begin
      dec.data_length = in_tdata[26:24];
    end
    dec.is_read = (in_tdata[15:8] == spf_pkg::READ_FLAGS);
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.entry = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/spf_back.sv -----
// ----------------------------------------------------------------------------
// spf_back: packet sequencer, reply checker and output register
// Emits one packet byte per cycle unless stalled; checker folds reply bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire spf_pkg::head_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output spf_pkg::result_t out_res
);

  spf_pkg::back_state_t state_r, state_nxt;
  logic [spf_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  tx_xor_r, tx_xor_nxt;

  logic        armed_r, armed_nxt;
  logic [2:0]  exp_len_r, exp_len_nxt;
  logic [spf_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic [7:0]  rx_xor_r, rx_xor_nxt;
  logic [31:0] accum_r, accum_nxt;

  logic             out_v_r;
  spf_pkg::result_t res_r;
  spf_pkg::result_t res;
  logic             emit;
  logic             adv;
  logic             frame_end;

  spf_pkg::entry_t  e;
  logic [spf_pkg::POS_W-1:0] last_pos;
  logic [spf_pkg::POS_W-1:0] doff;
  logic [spf_pkg::POS_W-1:0] rx_off;
  logic [7:0]  tx_b;
  logic [7:0]  data_b;
  logic [31:0] rx_shifted;

  assign e   = head.entry;
  assign adv = !out_v_r || out_tready;
  assign last_pos = spf_pkg::POS_DATA0 + {1'b0, e.data_length};
  assign doff     = pos_r - spf_pkg::POS_DATA0;
  assign rx_off   = idx_r - spf_pkg::POS_DATA0;
  assign frame_end = head.valid && adv && (e.kind == spf_pkg::KIND_FRAME) &&
                     (pos_r == last_pos);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spf_pkg::ST_IDLE: begin
        if (head.valid && adv && (e.kind == spf_pkg::KIND_FRAME) && !frame_end) begin
          state_nxt = spf_pkg::ST_SEND;
        end
      end
      spf_pkg::ST_SEND: begin
        if (frame_end) begin
          state_nxt = spf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spf_pkg::ST_IDLE;
    endcase
  end

  // data byte of the packet at the current position
  always_comb begin
    data_b = 8'h00;
    if (doff < 4'd4) begin
      unique case (doff[1:0])
        2'd0: data_b = e.data_word[7:0];
        2'd1: data_b = e.data_word[15:8];
        2'd2: data_b = e.data_word[23:16];
        2'd3: data_b = e.data_word[31:24];
        default: data_b = 8'h00;
      endcase
    end
  end

  always_comb begin
    priority if (pos_r == 4'd0) tx_b = spf_pkg::HDR0;
    else if (pos_r == 4'd1)     tx_b = spf_pkg::HDR1;
    else if (pos_r == 4'd2)     tx_b = e.servo_id;
    else if (pos_r == 4'd3)     tx_b = e.flag_byte;
    else if (pos_r == 4'd4)     tx_b = e.reg_address;
    else if (pos_r == 4'd5)     tx_b = {5'd0, e.data_length};
    else if (pos_r == 4'd6)     tx_b = e.servo_count;
    else if (pos_r == last_pos) tx_b = tx_xor_r;
    else                        tx_b = data_b;
  end

  always_comb begin
    rx_shifted = 32'd0;
    unique case (rx_off[1:0])
      2'd0: rx_shifted = {24'd0, e.rx_byte};
      2'd1: rx_shifted = {16'd0, e.rx_byte, 8'd0};
      2'd2: rx_shifted = {8'd0, e.rx_byte, 16'd0};
      2'd3: rx_shifted = {e.rx_byte, 24'd0};
      default: rx_shifted = 32'd0;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    res         = '0;
    pos_nxt     = pos_r;
    tx_xor_nxt  = tx_xor_r;
    armed_nxt   = armed_r;
    exp_len_nxt = exp_len_r;
    idx_nxt     = idx_r;
    rx_xor_nxt  = rx_xor_r;
    accum_nxt   = accum_r;
    if (head.valid && adv) begin
      unique case (e.kind)
        spf_pkg::KIND_FRAME: begin
          emit         = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = tx_b;
          if (frame_end) begin
            res.tx_last = 1'b1;
            pop         = 1'b1;
            pos_nxt     = '0;
            tx_xor_nxt  = 8'h00;
            if (e.is_read) begin
              armed_nxt   = 1'b1;
              exp_len_nxt = e.data_length;
              idx_nxt     = '0;
              rx_xor_nxt  = 8'h00;
              accum_nxt   = 32'd0;
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
            if (pos_r >= spf_pkg::POS_XOR0) begin
              tx_xor_nxt = tx_xor_r ^ tx_b;
            end
          end
        end
        spf_pkg::KIND_RX: begin
          pop = 1'b1;
          if (armed_r) begin
            if (idx_r == spf_pkg::POS_DATA0 + {1'b0, exp_len_r}) begin
              emit            = 1'b1;
              res.reply_valid = 1'b1;
              res.reply_ok    = (e.rx_byte == rx_xor_r);
              res.reply_data  = accum_r;
              armed_nxt       = 1'b0;
              idx_nxt         = '0;
              rx_xor_nxt      = 8'h00;
              accum_nxt       = 32'd0;
            end else begin
              if (idx_r >= spf_pkg::POS_XOR0) begin
                rx_xor_nxt = rx_xor_r ^ e.rx_byte;
              end
              if (idx_r >= spf_pkg::POS_DATA0 && rx_off < 4'd4) begin
                accum_nxt = accum_r | rx_shifted;
              end
              idx_nxt = idx_r + 4'd1;
            end
          end
        end
        default: pop = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spf_pkg::ST_IDLE;
      pos_r     <= '0;
      tx_xor_r  <= 8'h00;
      armed_r   <= 1'b0;
      exp_len_r <= 3'd0;
      idx_r     <= '0;
      rx_xor_r  <= 8'h00;
      accum_r   <= 32'd0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      tx_xor_r  <= tx_xor_nxt;
      armed_r   <= armed_nxt;
      exp_len_r <= exp_len_nxt;
      idx_r     <= idx_nxt;
      rx_xor_r  <= rx_xor_nxt;
      accum_r   <= accum_nxt;
      if (adv) begin
        out_v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_res    = res_r;

endmodule

`default_nettype wire

// ----- hdl/servo_packet_framer_and_reply_checker_unit.sv -----
// ----------------------------------------------------------------------------
// A taken frame beat is written into the two-entry queue; its packet bytes
// then pass through the output register. A frame holds the sequencer for
// 8 + length bytes; a reply byte is popped when the sequencer takes it.
// One byte per cycle from the sequencer, stalled by out_tready, sets the rate.
// Reset: rst_n synchronous, active low; empties the queue, disarms receiver.
// ----------------------------------------------------------------------------
// servo_packet_framer_and_reply_checker_unit
// Frames short servo packets with XOR checksum and checks read replies.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_packet_framer_and_reply_checker_unit #(
  // largest data length carried in a packet; longer requests are limited
  parameter int unsigned MAX_DATA_BYTES = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input beats
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata, low bit up: servo_id[7:0], flag_byte[15:8], reg_address[23:16],
  //   data_length[26:24], servo_count[34:27], data_word[66:35],
  //   rx_byte[74:67], zero pad[79:75]
  input  wire logic [spf_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: cmd (0 frame, 1 reply byte)
  input  wire logic                           in_tuser,
  // result beats
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata, low bit up: tx_byte[7:0], reply_ok[8], reply_data[40:9],
  //   zero pad[47:41]
  output logic [spf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // tuser, low bit up: tx_valid[0], reply_valid[1]
  output logic [1:0]                          out_tuser,
  // tlast: tx_last, set on the checksum byte
  output logic                                out_tlast
);

  spf_pkg::head_t   head;
  logic             pop;
  spf_pkg::result_t res;

  // front: decode, length limit, read detect, two-entry queue
  spf_front #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  // back: byte sequencer, reply checker, output register
  spf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {7'd0, res.reply_data, res.reply_ok, res.tx_byte};
  assign out_tuser = {res.reply_valid, res.tx_valid};
  assign out_tlast = res.tx_last;

endmodule

`default_nettype wire
